// ===== hw/rtl/pawc_pkg.sv =====
// ----------------------------------------------------------------------------
// pawc_pkg
// Shared types, codes and helpers of the particle advection wall clamp block.
// ----------------------------------------------------------------------------
package pawc_pkg;

    localparam int DIV_N_W = 47;
    localparam int DIV_D_W = 31;

    typedef enum logic [2:0] {
        CFG_STEP_TIME     = 3'd0,
        CFG_GRAVITY_X     = 3'd1,
        CFG_GRAVITY_Y     = 3'd2,
        CFG_GRAVITY_Z     = 3'd3,
        CFG_UPPER_LIMIT_X = 3'd4,
        CFG_UPPER_LIMIT_Y = 3'd5,
        CFG_UPPER_LIMIT_Z = 3'd6,
        CFG_DAMPING       = 3'd7
    } t_cfg_index;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    typedef enum logic [1:0] {
        WALL_NONE  = 2'd0,
        WALL_UPPER = 2'd1,
        WALL_LOWER = 2'd2
    } t_wall_hit;

    typedef struct packed {
        logic [1:0]         axis;
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic signed [31:0] acceleration;
        logic [30:0]        density;
        logic signed [31:0] smoothed_velocity;
        logic               last_particle;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] new_position;
        logic signed [31:0] new_velocity;
        logic signed [31:0] new_smoothed_velocity;
        logic [1:0]         wall_hit;
        logic               frame_end;
    } t_out_item;

    // Side information that travels with each item through the divider.
    typedef struct packed {
        logic [1:0]         axis;
        logic               last;
        logic               negative;
        logic signed [32:0] vel_grav;
        logic signed [31:0] position;
        logic signed [31:0] smoothed;
    } t_div_tag;

    function automatic logic signed [31:0] f_sat32(input logic signed [48:0] value);
        logic signed [31:0] result;
        if (value > 49'sh0_0000_7FFF_FFFF) begin
            result = 32'sh7FFF_FFFF;
        end else if (value < -49'sh0_0000_8000_0000) begin
            result = 32'sh8000_0000;
        end else begin
            result = value[31:0];
        end
        return result;
    endfunction

endpackage

// ===== hw/rtl/pawc_div.sv =====
// ----------------------------------------------------------------------------
// pawc_div
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// ----------------------------------------------------------------------------
module pawc_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [pawc_pkg::DIV_N_W-1:0]    i_dividend,
    input  logic [pawc_pkg::DIV_D_W-1:0]    i_divisor,
    input  pawc_pkg::t_div_tag              i_tag,
    output logic                            o_valid,
    output logic [pawc_pkg::DIV_N_W-1:0]    o_quotient,
    output pawc_pkg::t_div_tag              o_tag
);

    localparam int STEPS = pawc_pkg::DIV_N_W;
    localparam int NW    = pawc_pkg::DIV_N_W;
    localparam int DW    = pawc_pkg::DIV_D_W;

    logic [STEPS-1:0]   r_valid;
    logic [NW-1:0]      r_work [STEPS];
    logic [DW-1:0]      r_rem  [STEPS];
    logic [DW-1:0]      r_div  [STEPS];
    pawc_pkg::t_div_tag r_tag  [STEPS];

    logic [STEPS-1:0]   s_valid;
    logic [NW-1:0]      s_work [STEPS];
    logic [DW-1:0]      s_rem  [STEPS];
    logic [DW-1:0]      s_div  [STEPS];
    pawc_pkg::t_div_tag s_tag  [STEPS];

    logic [NW-1:0]      n_work [STEPS];
    logic [DW-1:0]      n_rem  [STEPS];

    always_comb begin
        s_valid[0] = i_valid;
        s_work[0]  = i_dividend;
        s_rem[0]   = '0;
        s_div[0]   = i_divisor;
        s_tag[0]   = i_tag;
        for (int k = 1; k < STEPS; k++) begin
            s_valid[k] = r_valid[k-1];
            s_work[k]  = r_work[k-1];
            s_rem[k]   = r_rem[k-1];
            s_div[k]   = r_div[k-1];
            s_tag[k]   = r_tag[k-1];
        end
    end

    // Each stage shifts one dividend bit into the remainder and one quotient bit
    // into the low end of the work word.
    always_comb begin
        logic [DW:0] trial;
        logic [DW:0] diff;
        for (int k = 0; k < STEPS; k++) begin
            trial = {s_rem[k], s_work[k][NW-1]};
            diff  = trial - {1'b0, s_div[k]};
            if (!diff[DW]) begin
                n_rem[k]  = diff[DW-1:0];
                n_work[k] = {s_work[k][NW-2:0], 1'b1};
            end else begin
                n_rem[k]  = trial[DW-1:0];
                n_work[k] = {s_work[k][NW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < STEPS; k++) begin
            r_work[k] <= n_work[k];
            r_rem[k]  <= n_rem[k];
            r_div[k]  <= s_div[k];
            r_tag[k]  <= s_tag[k];
        end
    end

    assign o_valid    = r_valid[STEPS-1];
    assign o_quotient = r_work[STEPS-1];
    assign o_tag      = r_tag[STEPS-1];

endmodule

// ===== hw/rtl/particle_advection_wall_clamp.sv =====
// ----------------------------------------------------------------------------
// particle_advection_wall_clamp
// One Euler step of a fluid particle axis with wall clamping and damping.
// ----------------------------------------------------------------------------
// The block takes one particle axis in every clock cycle and never raises
// o_busy. Each result appears on o_result for exactly one cycle with o_strobe
// high, in input order. Most of the pipeline is the divider for acceleration
// over density, which spends one pipeline stage per quotient bit (47 stages);
// the remaining stages hold the multipliers, adders and saturation logic.
// Configuration writes take effect at once; the user must make them only while
// no item is in flight, and the block does not enforce this.
module particle_advection_wall_clamp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  pawc_pkg::t_in_item    i_item,
    output logic                  o_strobe,
    output pawc_pkg::t_out_item   o_result,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data
);

    logic [23:0]        r_step_time;
    logic signed [31:0] r_gravity [3];
    logic [30:0]        r_upper   [3];
    logic signed [15:0] r_damping;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_time <= 24'd50332;
            r_gravity[0] <= 32'sd0;
            r_gravity[1] <= 32'sd445645;
            r_gravity[2] <= 32'sd0;
            r_upper[0] <= 31'd41943;
            r_upper[1] <= 31'd41943;
            r_upper[2] <= 31'd41943;
            r_damping <= -16'sd8192;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pawc_pkg::CFG_STEP_TIME:     r_step_time  <= i_cfg_data[23:0];
                pawc_pkg::CFG_GRAVITY_X:     r_gravity[0] <= i_cfg_data;
                pawc_pkg::CFG_GRAVITY_Y:     r_gravity[1] <= i_cfg_data;
                pawc_pkg::CFG_GRAVITY_Z:     r_gravity[2] <= i_cfg_data;
                pawc_pkg::CFG_UPPER_LIMIT_X: r_upper[0]   <= i_cfg_data[30:0];
                pawc_pkg::CFG_UPPER_LIMIT_Y: r_upper[1]   <= i_cfg_data[30:0];
                pawc_pkg::CFG_UPPER_LIMIT_Z: r_upper[2]   <= i_cfg_data[30:0];
                pawc_pkg::CFG_DAMPING:       r_damping    <= i_cfg_data[15:0];
            endcase
        end
    end

    assign o_busy = 1'b0;

    logic signed [24:0] step_signed;
    assign step_signed = $signed({1'b0, r_step_time});

    // Stage 0: input register, axis and density fix-ups.
    logic               r_s0_valid;
    logic [1:0]         r_s0_axis;
    logic signed [31:0] r_s0_pos;
    logic signed [31:0] r_s0_vel;
    logic signed [31:0] r_s0_acc;
    logic [30:0]        r_s0_dens;
    logic signed [31:0] r_s0_sv;
    logic               r_s0_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else begin
            r_s0_valid <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_axis <= (i_item.axis > pawc_pkg::AXIS_Z) ? pawc_pkg::AXIS_Z : i_item.axis;
        r_s0_pos  <= i_item.position;
        r_s0_vel  <= i_item.velocity;
        r_s0_acc  <= i_item.acceleration;
        r_s0_dens <= (i_item.density == '0) ? 31'd1 : i_item.density;
        r_s0_sv   <= i_item.smoothed_velocity;
        r_s0_last <= i_item.last_particle;
    end

    // Stage 1: acceleration and gravity times the time step.
    logic               r_s1_valid;
    logic [1:0]         r_s1_axis;
    logic signed [31:0] r_s1_pos;
    logic signed [31:0] r_s1_vel;
    logic signed [56:0] r_s1_acc_prod;
    logic signed [56:0] r_s1_grav_prod;
    logic [30:0]        r_s1_dens;
    logic signed [31:0] r_s1_sv;
    logic               r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= r_s0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_axis      <= r_s0_axis;
        r_s1_pos       <= r_s0_pos;
        r_s1_vel       <= r_s0_vel;
        r_s1_acc_prod  <= r_s0_acc * step_signed;
        r_s1_grav_prod <= r_gravity[r_s0_axis] * step_signed;
        r_s1_dens      <= r_s0_dens;
        r_s1_sv        <= r_s0_sv;
        r_s1_last      <= r_s0_last;
    end

    // Stage 2: dividend magnitude, and velocity plus the gravity term.
    logic               r_s2_valid;
    logic [46:0]        r_s2_dividend;
    logic [30:0]        r_s2_dens;
    pawc_pkg::t_div_tag r_s2_tag;

    logic signed [56:0] acc_mag;
    logic signed [31:0] grav_term;

    assign acc_mag   = r_s1_acc_prod[56] ? -r_s1_acc_prod : r_s1_acc_prod;
    assign grav_term = r_s1_grav_prod[55:24];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_dividend          <= acc_mag[54:8];
        r_s2_dens              <= r_s1_dens;
        r_s2_tag.axis          <= r_s1_axis;
        r_s2_tag.last          <= r_s1_last;
        r_s2_tag.negative      <= r_s1_acc_prod[56];
        r_s2_tag.vel_grav      <= {r_s1_vel[31], r_s1_vel} + {grav_term[31], grav_term};
        r_s2_tag.position      <= r_s1_pos;
        r_s2_tag.smoothed      <= r_s1_sv;
    end

    logic               div_valid;
    logic [46:0]        div_quotient;
    pawc_pkg::t_div_tag div_tag;

    pawc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_s2_valid),
        .i_dividend (r_s2_dividend),
        .i_divisor  (r_s2_dens),
        .i_tag      (r_s2_tag),
        .o_valid    (div_valid),
        .o_quotient (div_quotient),
        .o_tag      (div_tag)
    );

    // Stage 3: signed acceleration term added to velocity and gravity term.
    logic               r_s3_valid;
    logic signed [48:0] r_s3_sum;
    pawc_pkg::t_div_tag r_s3_tag;

    logic signed [47:0] acc_term;
    assign acc_term = div_tag.negative ? -$signed({1'b0, div_quotient})
                                       :  $signed({1'b0, div_quotient});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_sum <= {{16{div_tag.vel_grav[32]}}, div_tag.vel_grav}
                  + {acc_term[47], acc_term};
        r_s3_tag <= div_tag;
    end

    // Stage 4: saturated new velocity.
    logic               r_s4_valid;
    logic signed [31:0] r_s4_nv;
    pawc_pkg::t_div_tag r_s4_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_nv  <= pawc_pkg::f_sat32(r_s3_sum);
        r_s4_tag <= r_s3_tag;
    end

    // Stage 5: displacement and damped velocity products.
    logic               r_s5_valid;
    logic signed [31:0] r_s5_nv;
    logic signed [56:0] r_s5_pos_prod;
    logic signed [47:0] r_s5_damp_prod;
    pawc_pkg::t_div_tag r_s5_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
        end else begin
            r_s5_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s5_nv        <= r_s4_nv;
        r_s5_pos_prod  <= r_s4_nv * step_signed;
        r_s5_damp_prod <= r_s4_nv * r_damping;
        r_s5_tag       <= r_s4_tag;
    end

    // Stage 6: unclamped position sum and saturated damped velocity.
    logic               r_s6_valid;
    logic signed [31:0] r_s6_nv;
    logic signed [31:0] r_s6_damped;
    logic signed [32:0] r_s6_pos_sum;
    pawc_pkg::t_div_tag r_s6_tag;

    logic signed [31:0] disp;
    logic signed [33:0] damp_shift;
    assign disp       = r_s5_pos_prod[55:24];
    assign damp_shift = r_s5_damp_prod[47:14];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_valid <= 1'b0;
        end else begin
            r_s6_valid <= r_s5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s6_nv      <= r_s5_nv;
        r_s6_damped  <= pawc_pkg::f_sat32({{15{damp_shift[33]}}, damp_shift});
        r_s6_pos_sum <= {r_s5_tag.position[31], r_s5_tag.position} + {disp[31], disp};
        r_s6_tag     <= r_s5_tag;
    end

    // Stage 7: wall tests and clamping.
    logic               r_s7_valid;
    logic signed [31:0] r_s7_pos;
    logic signed [31:0] r_s7_nv;
    logic [1:0]         r_s7_hit;
    logic signed [31:0] r_s7_sv;
    logic               r_s7_last;

    logic signed [31:0] pos_sat;
    logic signed [31:0] upper_signed;
    logic signed [31:0] n_s7_pos;
    logic signed [31:0] n_s7_nv;
    logic [1:0]         n_s7_hit;

    assign pos_sat      = pawc_pkg::f_sat32({{16{r_s6_pos_sum[32]}}, r_s6_pos_sum});
    assign upper_signed = $signed({1'b0, r_upper[r_s6_tag.axis]});

    always_comb begin
        priority if (pos_sat >= upper_signed) begin
            n_s7_pos = upper_signed;
            n_s7_nv  = r_s6_damped;
            n_s7_hit = pawc_pkg::WALL_UPPER;
        end else if (pos_sat < 32'sd0) begin
            n_s7_pos = '0;
            n_s7_nv  = r_s6_damped;
            n_s7_hit = pawc_pkg::WALL_LOWER;
        end else begin
            n_s7_pos = pos_sat;
            n_s7_nv  = r_s6_nv;
            n_s7_hit = pawc_pkg::WALL_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_valid <= 1'b0;
        end else begin
            r_s7_valid <= r_s6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s7_pos  <= n_s7_pos;
        r_s7_nv   <= n_s7_nv;
        r_s7_hit  <= n_s7_hit;
        r_s7_sv   <= r_s6_tag.smoothed;
        r_s7_last <= r_s6_tag.last;
    end

    // Output stage: smoothed velocity and the result register.
    logic                r_out_valid;
    pawc_pkg::t_out_item r_out;

    logic signed [32:0] sv_sum;
    assign sv_sum = {r_s7_sv[31], r_s7_sv} + {r_s7_nv[31], r_s7_nv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_s7_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.new_position          <= r_s7_pos;
        r_out.new_velocity          <= r_s7_nv;
        r_out.new_smoothed_velocity <= sv_sum[32:1];
        r_out.wall_hit              <= r_s7_hit;
        r_out.frame_end             <= r_s7_last;
    end

    assign o_strobe = r_out_valid;
    assign o_result = r_out;

endmodule
